[hw/rtl/spma_pkg.sv]
// ----------------------------------------------------------------------------
// spma_pkg
// Shared codes, field widths and control types for the sparse polynomial
// merge-add block.
// ----------------------------------------------------------------------------
package spma_pkg;

  // field widths of one term and one sum
  localparam int EXP_W  = 16;
  localparam int COEF_W = 32;
  localparam int SUM_W  = COEF_W + 1;
  localparam int TERM_W = EXP_W + COEF_W;

  // stream word widths, padded to whole bytes
  localparam int S_TDATA_W = ((TERM_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((EXP_W + SUM_W + 7) / 8) * 8;
  localparam int OP_W      = 2;

  // operation codes carried on s_tuser
  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

  // run request from the load side to the merge engine
  typedef struct packed {
    logic start;
    logic dropped;
  } run_ctrl_t;

  // merge engine status back to the load side
  typedef struct packed {
    logic busy;
  } merge_stat_t;

endpackage

[hw/rtl/sparse_polynomial_merge_add_core.sv]
// ----------------------------------------------------------------------------
// sparse_polynomial_merge_add_core
// Loads two sparse polynomials term by term and streams out their sum.
// ----------------------------------------------------------------------------
// Load words (s_tuser = 0 or 1) and unused op codes are taken while the merge
// is idle; a load into a full list is dropped and reported on the overflow
// bit of the next run. A run word (s_tuser = 2) starts the merge, each result
// word set by one read from each term memory; the run word is registered into
// the sequencer state before the first result word enters the output register.
// A run over lists of n1 and n2 terms gives at most n1 + n2 results (one empty
// result when both are empty) and the input stays stalled until the final
// result is in the output register. Back pressure on m_tready stalls the
// merge. The term memories need no clearing after reset.
module sparse_polynomial_merge_add_core #(
  parameter int TERM_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [spma_pkg::S_TDATA_W-1:0] s_tdata,  // exponent, coefficient
  input  logic [spma_pkg::OP_W-1:0]      s_tuser,  // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [spma_pkg::M_TDATA_W-1:0] m_tdata,  // sum_exponent, sum_coefficient, zero pad
  output logic                           m_tlast,
  output logic [1:0]                     m_tuser   // term_valid, overflow
);

  localparam int CNT_W = $clog2(TERM_DEPTH + 1);
  localparam int AW    = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
  localparam int TW    = spma_pkg::TERM_W;

  logic [CNT_W-1:0] first_count, second_count;
  logic             dropped_flag;
  logic             accept;
  logic             we_first, we_second;
  logic             full_first, full_second;
  logic [TW-1:0]    term;

  spma_pkg::run_ctrl_t   run;
  spma_pkg::merge_stat_t stat;

  logic [AW-1:0] first_raddr, second_raddr;
  logic [TW-1:0] first_rdata, second_rdata;

  assign s_tready    = !stat.busy;
  assign accept      = s_tvalid && s_tready;
  assign term        = s_tdata[TW-1:0];
  assign full_first  = first_count >= CNT_W'(TERM_DEPTH);
  assign full_second = second_count >= CNT_W'(TERM_DEPTH);
  assign we_first    = accept && (s_tuser == spma_pkg::OP_LOAD_FIRST) && !full_first;
  assign we_second   = accept && (s_tuser == spma_pkg::OP_LOAD_SECOND) && !full_second;

  assign run.start   = accept && (s_tuser == spma_pkg::OP_RUN);
  assign run.dropped = dropped_flag;

  // list counts and drop flag, cleared by a run
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
    end else if (run.start) begin
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
    end else if (accept) begin
      if (we_first) begin
        first_count <= first_count + CNT_W'(1);
      end
      if (we_second) begin
        second_count <= second_count + CNT_W'(1);
      end
      if ((s_tuser == spma_pkg::OP_LOAD_FIRST && full_first) ||
          (s_tuser == spma_pkg::OP_LOAD_SECOND && full_second)) begin
        dropped_flag <= 1'b1;
      end
    end
  end

  // term memories
  spma_ram #(.WIDTH(TW), .DEPTH(TERM_DEPTH), .AW(AW)) u_first_ram (
    .clk   (clk),
    .we    (we_first),
    .waddr (first_count[AW-1:0]),
    .wdata (term),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  spma_ram #(.WIDTH(TW), .DEPTH(TERM_DEPTH), .AW(AW)) u_second_ram (
    .clk   (clk),
    .we    (we_second),
    .waddr (second_count[AW-1:0]),
    .wdata (term),
    .raddr (second_raddr),
    .rdata (second_rdata)
  );

  // merge engine
  spma_merge #(.TERM_DEPTH(TERM_DEPTH), .CNT_W(CNT_W), .AW(AW)) u_merge (
    .clk          (clk),
    .rst          (rst),
    .run          (run),
    .first_count  (first_count),
    .second_count (second_count),
    .stat         (stat),
    .first_raddr  (first_raddr),
    .first_rdata  (first_rdata),
    .second_raddr (second_raddr),
    .second_rdata (second_rdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

  // counts stay within the memory depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (first_count <= CNT_W'(TERM_DEPTH)) && (second_count <= CNT_W'(TERM_DEPTH)))
    else $error("list count beyond depth");

  // a run leaves both lists empty and the drop flag clear
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    run.start |=> (first_count == '0) && (second_count == '0) && !dropped_flag)
    else $error("run did not clear list state");

  // no memory write while the merge is reading
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !we_first && !we_second)
    else $error("term write during merge");

endmodule

[hw/rtl/spma_ram.sv]
// ----------------------------------------------------------------------------
// spma_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module spma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/spma_merge.sv]
// ----------------------------------------------------------------------------
// spma_merge
// Merge engine: walks both term memories with one read pointer each, compares the
// two head terms and emits one sum term per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module spma_merge #(
  parameter int TERM_DEPTH = 32,
  parameter int CNT_W      = $clog2(TERM_DEPTH + 1),
  parameter int AW         = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  spma_pkg::run_ctrl_t        run,
  input  logic [CNT_W-1:0]           first_count,
  input  logic [CNT_W-1:0]           second_count,
  output spma_pkg::merge_stat_t      stat,
  output logic [AW-1:0]              first_raddr,
  input  logic [spma_pkg::TERM_W-1:0] first_rdata,
  output logic [AW-1:0]              second_raddr,
  input  logic [spma_pkg::TERM_W-1:0] second_rdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [spma_pkg::M_TDATA_W-1:0] m_tdata,  // sum_exponent, sum_coefficient, zero pad
  output logic                       m_tlast,
  output logic [1:0]                 m_tuser   // term_valid, overflow
);

  localparam int EXP_W  = spma_pkg::EXP_W;
  localparam int COEF_W = spma_pkg::COEF_W;
  localparam int SUM_W  = spma_pkg::SUM_W;
  localparam int PAD_W  = spma_pkg::M_TDATA_W - EXP_W - SUM_W;

  typedef enum logic [1:0] {
    IDLE  = 2'b01,
    MERGE = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] ptr_a, ptr_a_next;
  logic [CNT_W-1:0] ptr_b, ptr_b_next;
  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic             dropped;

  // output register
  logic             out_valid;
  logic [EXP_W-1:0] out_exp;
  logic [SUM_W-1:0] out_coef;
  logic             out_term;
  logic             out_last;
  logic             out_ovf;

  // head terms and merge decision
  logic [EXP_W-1:0]  exp_a, exp_b;
  logic [COEF_W-1:0] coef_a, coef_b;
  logic [SUM_W-1:0]  ext_a, ext_b;
  logic              has_a, has_b, adv_a, adv_b;
  logic [CNT_W-1:0]  after_a, after_b;
  logic              take, emit, is_last;
  logic [EXP_W-1:0]  emit_exp;
  logic [SUM_W-1:0]  emit_coef;
  logic              emit_term;

  assign exp_a  = first_rdata[EXP_W-1:0];
  assign coef_a = first_rdata[spma_pkg::TERM_W-1:EXP_W];
  assign exp_b  = second_rdata[EXP_W-1:0];
  assign coef_b = second_rdata[spma_pkg::TERM_W-1:EXP_W];
  assign ext_a  = {coef_a[COEF_W-1], coef_a};
  assign ext_b  = {coef_b[COEF_W-1], coef_b};
  assign has_a  = ptr_a < cnt_a;
  assign has_b  = ptr_b < cnt_b;

  // pick the larger-exponent head or add equal heads; a lone head passes, none gives an empty term
  always_comb begin
    adv_a     = 1'b0;
    adv_b     = 1'b0;
    emit_exp  = '0;
    emit_coef = '0;
    emit_term = 1'b1;
    if (has_a && has_b) begin
      if (exp_a == exp_b) begin
        adv_a     = 1'b1;
        adv_b     = 1'b1;
        emit_exp  = exp_a;
        emit_coef = ext_a + ext_b;
      end else if (exp_a > exp_b) begin
        adv_a     = 1'b1;
        emit_exp  = exp_a;
        emit_coef = ext_a;
      end else begin
        adv_b     = 1'b1;
        emit_exp  = exp_b;
        emit_coef = ext_b;
      end
    end else if (has_a) begin
      adv_a     = 1'b1;
      emit_exp  = exp_a;
      emit_coef = ext_a;
    end else if (has_b) begin
      adv_b     = 1'b1;
      emit_exp  = exp_b;
      emit_coef = ext_b;
    end else begin
      emit_term = 1'b0;
    end
  end

  assign after_a = ptr_a + CNT_W'(adv_a);
  assign after_b = ptr_b + CNT_W'(adv_b);
  assign is_last = (after_a >= cnt_a) && (after_b >= cnt_b);
  assign take    = !out_valid || m_tready;
  assign emit    = (state == MERGE) && take;

  // sequencer and read pointers
  always_comb begin
    state_next = state;
    ptr_a_next = ptr_a;
    ptr_b_next = ptr_b;
    case (state)
      IDLE: begin
        if (run.start) begin
          state_next = MERGE;
        end
      end
      MERGE: begin
        if (take) begin
          if (is_last) begin
            state_next = IDLE;
            ptr_a_next = '0;
            ptr_b_next = '0;
          end else begin
            ptr_a_next = after_a;
            ptr_b_next = after_b;
          end
        end
      end
      default: begin
        state_next = IDLE;
        ptr_a_next = '0;
        ptr_b_next = '0;
      end
    endcase
  end

  // memories read at the next pointer so data lines up with the pointer
  assign first_raddr  = ptr_a_next[AW-1:0];
  assign second_raddr = ptr_b_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ptr_a     <= '0;
      ptr_b     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr_a <= ptr_a_next;
      ptr_b <= ptr_b_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // run snapshot and result payload
  always_ff @(posedge clk) begin
    if (state == IDLE && run.start) begin
      cnt_a   <= first_count;
      cnt_b   <= second_count;
      dropped <= run.dropped;
    end
    if (emit) begin
      out_exp  <= emit_exp;
      out_coef <= emit_coef;
      out_term <= emit_term;
      out_last <= is_last;
      out_ovf  <= dropped;
    end
  end

  assign stat.busy = (state == MERGE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{PAD_W{1'b0}}, out_coef, out_exp};
  assign m_tlast   = out_last;
  assign m_tuser   = {out_ovf, out_term};

  // pointers never run past their list
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == MERGE) |-> (ptr_a <= cnt_a) && (ptr_b <= cnt_b))
    else $error("merge pointer past list count");

  // a run only starts while the engine is idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    run.start |-> (state == IDLE))
    else $error("run request while merging");

  // the empty result is always the single, final word of a run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_term) |-> out_last)
    else $error("empty result not marked last");

  // pointers rewind after every run
  a_idle_rewind: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (ptr_a == '0) && (ptr_b == '0))
    else $error("pointers not rewound in idle");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sparse_polynomial_merge_add_core: loads term lists,
// runs merges and checks every sum word against an in-bench merge predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int OP_W      = spma_pkg::OP_W;
  localparam int EXP_W     = spma_pkg::EXP_W;
  localparam int COEF_W    = spma_pkg::COEF_W;
  localparam int SUM_W     = spma_pkg::SUM_W;
  localparam int S_TDATA_W = spma_pkg::S_TDATA_W;
  localparam int M_TDATA_W = spma_pkg::M_TDATA_W;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LIST_DEPTH = 32;

  typedef struct {
    logic [EXP_W-1:0]         expo;
    logic signed [COEF_W-1:0] coef;
  } poly_term_t;

  typedef struct {
    logic [EXP_W-1:0]        expo;
    logic signed [SUM_W-1:0] coef;
    logic                    has_term;
    logic                    last;
    logic                    dropped;
  } sum_term_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // exponent, coefficient
  logic [OP_W-1:0]      s_tuser = '0;  // op
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // sum_exponent, sum_coefficient, zero pad
  logic                 m_tlast;
  logic [1:0]           m_tuser;       // term_valid, overflow

  // predictor state
  poly_term_t first_list [LIST_DEPTH];
  poly_term_t second_list [LIST_DEPTH];
  int         first_len = 0;
  int         second_len = 0;
  logic       drop_seen = 1'b0;
  sum_term_t  sum_queue [$];

  int error_count = 0;
  int words_sent = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  sparse_polynomial_merge_add_core #(
    .TERM_DEPTH(LIST_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // random back pressure on the result side
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // merge predictor, applied to every accepted word
  task automatic apply_word(input logic [OP_W-1:0] op, input logic [EXP_W-1:0] e,
                            input logic [COEF_W-1:0] c);
    int        i;
    int        j;
    sum_term_t s;
    i = 0;
    j = 0;
    s.has_term = 1'b1;
    s.last = 1'b0;
    s.dropped = drop_seen;
    case (op)
      spma_pkg::OP_LOAD_FIRST: begin
        if (first_len < LIST_DEPTH) begin
          first_list[first_len] = '{e, c};
          first_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      spma_pkg::OP_LOAD_SECOND: begin
        if (second_len < LIST_DEPTH) begin
          second_list[second_len] = '{e, c};
          second_len++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      spma_pkg::OP_RUN: begin
        // merge on head terms only
        while (i < first_len || j < second_len) begin
          if (i < first_len && j < second_len &&
              first_list[i].expo == second_list[j].expo) begin
            s.expo = first_list[i].expo;
            s.coef = SUM_W'(first_list[i].coef) + SUM_W'(second_list[j].coef);
            i++;
            j++;
          end else if (j >= second_len ||
                       (i < first_len && first_list[i].expo > second_list[j].expo)) begin
            s.expo = first_list[i].expo;
            s.coef = SUM_W'(first_list[i].coef);
            i++;
          end else begin
            s.expo = second_list[j].expo;
            s.coef = SUM_W'(second_list[j].coef);
            j++;
          end
          s.last = (i >= first_len && j >= second_len);
          sum_queue.push_back(s);
        end
        // both lists empty
        if (first_len == 0 && second_len == 0) begin
          s.expo = '0;
          s.coef = '0;
          s.has_term = 1'b0;
          s.last = 1'b1;
          sum_queue.push_back(s);
        end
        first_len = 0;
        second_len = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    logic [EXP_W-1:0]        got_expo;
    logic signed [SUM_W-1:0] got_coef;
    sum_term_t               want;
    if (!rst && m_tvalid && m_tready) begin
      got_expo = m_tdata[EXP_W-1:0];
      got_coef = m_tdata[EXP_W+SUM_W-1:EXP_W];
      if (sum_queue.size() == 0) begin
        $error("unexpected sum word: exponent %0d coefficient %0d", got_expo, got_coef);
        error_count++;
      end else begin
        want = sum_queue.pop_front();
        if (got_expo !== want.expo) begin
          $error("sum_exponent: expected %0d, got %0d", want.expo, got_expo);
          error_count++;
        end
        if (got_coef !== want.coef) begin
          $error("sum_coefficient: expected %0d, got %0d", want.coef, got_coef);
          error_count++;
        end
        if (m_tuser[0] !== want.has_term) begin
          $error("term_valid: expected %0b, got %0b", want.has_term, m_tuser[0]);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          error_count++;
        end
        if (m_tuser[1] !== want.dropped) begin
          $error("overflow: expected %0b, got %0b", want.dropped, m_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // send one word; entered and left at a falling edge
  task automatic send_word(input logic [OP_W-1:0] op, input logic [EXP_W-1:0] e,
                           input logic [COEF_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {c, e};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_word(op, e, c);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // two descending lists sharing some exponents, then a run
  task automatic send_poly_pair(input bit deep_lists);
    logic [EXP_W-1:0]  pool [$];
    logic [EXP_W-1:0]  e;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    int                n;
    int                step;
    n = deep_lists ? $urandom_range(66, 50) : $urandom_range(10, 0);
    e = (deep_lists || $urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
    for (int k = 0; k < n; k++) begin
      pool.push_back(e);
      if (e == 0) break;
      step = $urandom_range(deep_lists ? 800 : 4000, 1);
      e = (e > step) ? 16'(e - step) : 16'd0;
    end
    foreach (pool[k]) begin
      c1 = rand_coef();
      c2 = ($urandom_range(3) == 0) ? -c1 : rand_coef();
      case ($urandom_range(2))
        0: send_word(spma_pkg::OP_LOAD_FIRST, pool[k], c1);
        1: send_word(spma_pkg::OP_LOAD_SECOND, pool[k], c1);
        default: begin
          if ($urandom_range(1)) begin
            send_word(spma_pkg::OP_LOAD_FIRST, pool[k], c1);
            send_word(spma_pkg::OP_LOAD_SECOND, pool[k], c2);
          end else begin
            send_word(spma_pkg::OP_LOAD_SECOND, pool[k], c2);
            send_word(spma_pkg::OP_LOAD_FIRST, pool[k], c1);
          end
        end
      endcase
    end
    send_word(spma_pkg::OP_RUN, 16'($urandom), $urandom);
  endtask

  // unsorted loads and unused ops ahead of a run
  task automatic send_noise();
    int n;
    n = $urandom_range(8, 1);
    repeat (n) begin
      case ($urandom_range(3))
        0: send_word(OP_UNUSED, 16'($urandom), $urandom);
        1: send_word(spma_pkg::OP_LOAD_FIRST, 16'($urandom), rand_coef());
        default: send_word(spma_pkg::OP_LOAD_SECOND, 16'($urandom), rand_coef());
      endcase
    end
    send_word(spma_pkg::OP_RUN, 16'($urandom), $urandom);
  endtask

  // extreme exponents and coefficients, zero sum kept
  task automatic test_extreme_terms();
    send_word(spma_pkg::OP_LOAD_FIRST, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(spma_pkg::OP_LOAD_FIRST, 16'd100, 32'hFFFF_FFFF);
    send_word(spma_pkg::OP_LOAD_FIRST, 16'd0, 32'h8000_0000);
    send_word(spma_pkg::OP_LOAD_SECOND, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(spma_pkg::OP_LOAD_SECOND, 16'd100, 32'd1);
    send_word(spma_pkg::OP_LOAD_SECOND, 16'd50, 32'd5);
    send_word(spma_pkg::OP_LOAD_SECOND, 16'd0, 32'h8000_0000);
    send_word(spma_pkg::OP_RUN, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // empty run, unused op, one list only
  task automatic test_empty_and_single();
    send_word(spma_pkg::OP_RUN, '0, '0);
    send_word(OP_UNUSED, 16'hA5A5, 32'h1234_5678);
    send_word(spma_pkg::OP_RUN, '0, '0);
    send_word(spma_pkg::OP_LOAD_FIRST, 16'd7, 32'd3);
    send_word(spma_pkg::OP_RUN, '0, '0);
    send_word(spma_pkg::OP_LOAD_SECOND, 16'd9, -32'sd2);
    send_word(spma_pkg::OP_RUN, '0, '0);
  endtask

  // lists out of order merge as stored
  task automatic test_unsorted_lists();
    send_word(spma_pkg::OP_LOAD_FIRST, 16'd5, 32'd1);
    send_word(spma_pkg::OP_LOAD_FIRST, 16'd20, 32'd2);
    send_word(spma_pkg::OP_LOAD_SECOND, 16'd10, 32'd3);
    send_word(spma_pkg::OP_LOAD_SECOND, 16'd5, 32'd4);
    send_word(spma_pkg::OP_RUN, '0, '0);
  endtask

  // deep lists that can overrun the depth, then a clean empty run
  task automatic test_full_lists();
    send_poly_pair(1'b1);
    send_word(spma_pkg::OP_RUN, '0, '0);
  endtask

  task automatic test_random_runs(input int quota);
    int start;
    start = words_sent;
    while (words_sent - start < quota) begin
      case ($urandom_range(19))
        0, 1: send_noise();
        2: send_poly_pair(1'b1);
        default: send_poly_pair(1'b0);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_pct = 11;
    sink_stall_pct = 45;
    test_extreme_terms();
    test_empty_and_single();
    test_unsorted_lists();
    test_full_lists();
    test_random_runs(80);

    src_idle_pct = 45;
    sink_stall_pct = 11;
    test_random_runs(80);

    src_idle_pct = 0;
    sink_stall_pct = 0;
    test_random_runs(80);

    s_tvalid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sum_queue.size() != 0) begin
      $error("%0d sum words never arrived", sum_queue.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run time limit
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
